// ===== rtl/tpdc_pkg.sv =====
package tpdc_pkg;

  localparam logic [1:0] ACT_PERIODIC = 2'd0;
  localparam logic [1:0] ACT_PWM      = 2'd1;
  localparam logic [1:0] ACT_DUTY     = 2'd2;
  localparam logic [1:0] ACT_NONE     = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int MUL_W        = 32;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int DIV_FULL_W   = 64;
  localparam int DIV_NARROW_W = 48;
  localparam int DVS_W        = 32;

  typedef struct packed {
    logic               start;
    logic [MUL_W-1:0]   a;
    logic [MUL_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [PROD_W-1:0]  prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                  start;
    logic                  narrow;
    logic [DIV_FULL_W-1:0] dividend;
    logic [DVS_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_FULL_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/tpdc_if.sv =====
interface tpdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] period_len;
  logic [31:0] duty_us;

  modport source (output valid, action, period_len, duty_us, input ready);
  modport sink   (input valid, action, period_len, duty_us, output ready);
endinterface

interface tpdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prescaler;
  logic [15:0] reload;
  logic [15:0] compare;
  logic [1:0]  status;

  modport source (output valid, prescaler, reload, compare, status, input ready);
  modport sink   (input valid, prescaler, reload, compare, status, output ready);
endinterface

// ===== rtl/timer_period_duty_calculator.sv =====
// Timer prescaler and reload calculator. Each input word carries an action
// (periodic period, PWM period and duty, or duty only), a period and a duty in
// microseconds, and yields one result word with prescaler, reload, compare and
// status; action 3 is taken and dropped. One word is worked on at a time. All
// arithmetic runs one bit per cycle through a shared shift-add multiplier
// and a shared restoring divider (a 64-bit division by one million, 48-bit
// divisions for the others). A periodic request divides twice more when the
// count does not fit the reload, a PWM request adds a product and a division.
// The user must write the timer clock register through cfg_we and cfg_wdata
// only while idle; the block itself does not enforce this.
module timer_period_duty_calculator #(
  parameter int unsigned COUNT_MAX = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  tpdc_in_if.sink           in_ch,
  tpdc_out_if.source        out_ch
);

  localparam logic [31:0] US_PER_S = 32'd1000000;
  localparam logic [15:0] LIMIT16  = 16'hFFFF;
  localparam int          CNT_BITS = tpdc_pkg::DIV_NARROW_W;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_MUL1    = 10'b0000000010,
    S_DIV_US  = 10'b0000000100,
    S_DIV_CM  = 10'b0000001000,
    S_DIV_RLD = 10'b0000010000,
    S_CMP     = 10'b0000100000,
    S_MUL2    = 10'b0001000000,
    S_DIV_CMP = 10'b0010000000,
    S_DIV_PSC = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [31:0]         clk_hz_r;
  logic [1:0]          act_r, act_nxt;
  logic [31:0]         period_r, period_nxt;
  logic [31:0]         duty_r, duty_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [15:0]         psc_r, psc_nxt;
  logic [15:0]         rld_r, rld_nxt;
  logic [15:0]         cmp_r, cmp_nxt;
  logic                sat_r, sat_nxt;
  logic [15:0]         held_r, held_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic [15:0]         out_psc_r, out_rld_r, out_cmp_r;
  logic [1:0]          out_status_r, status_now;

  tpdc_pkg::mul_req_t  mul_req;
  tpdc_pkg::mul_rsp_t  mul_rsp;
  tpdc_pkg::div_req_t  div_req;
  tpdc_pkg::div_rsp_t  div_rsp;

  logic                accept;
  logic [31:0]         clk_op;
  logic                quot_big;
  logic [15:0]         quot16;
  logic [CNT_BITS-1:0] count_q;

  tpdc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  tpdc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign accept   = in_ch.valid && in_ch.ready;
  assign clk_op   = (in_ch.action == tpdc_pkg::ACT_PERIODIC) ?
                    {1'b0, clk_hz_r[31:1]} : clk_hz_r;
  assign quot_big = |div_rsp.quot[tpdc_pkg::DIV_FULL_W-1:16];
  assign quot16   = quot_big ? LIMIT16 : div_rsp.quot[15:0];
  assign count_q  = (div_rsp.quot == '0) ? CNT_BITS'(1) : div_rsp.quot[CNT_BITS-1:0];
  assign status_now = (act_r == tpdc_pkg::ACT_PWM && period_r == '0) ? tpdc_pkg::ST_ZERO :
                      sat_r ? tpdc_pkg::ST_SAT : tpdc_pkg::ST_OK;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    period_nxt    = period_r;
    duty_nxt      = duty_r;
    count_nxt     = count_r;
    psc_nxt       = psc_r;
    rld_nxt       = rld_r;
    cmp_nxt       = cmp_r;
    sat_nxt       = sat_r;
    held_nxt      = held_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_req       = '0;
    div_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.action != tpdc_pkg::ACT_NONE) begin
          act_nxt       = in_ch.action;
          period_nxt    = in_ch.period_len;
          duty_nxt      = in_ch.duty_us;
          psc_nxt       = (in_ch.action == tpdc_pkg::ACT_DUTY) ? held_r : '0;
          rld_nxt       = '0;
          cmp_nxt       = '0;
          sat_nxt       = 1'b0;
          mul_req.start = 1'b1;
          mul_req.a     = clk_op;
          mul_req.b     = (in_ch.action == tpdc_pkg::ACT_DUTY) ?
                          in_ch.duty_us : in_ch.period_len;
          state_nxt     = S_MUL1;
        end
      end
      S_MUL1: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = mul_rsp.prod;
          div_req.divisor  = US_PER_S;
          state_nxt        = S_DIV_US;
        end
      end
      S_DIV_US: begin
        if (div_rsp.done) begin
          if (act_r == tpdc_pkg::ACT_DUTY) begin
            div_req.start    = 1'b1;
            div_req.narrow   = 1'b1;
            div_req.dividend = div_rsp.quot;
            div_req.divisor  = 32'({1'b0, psc_r}) + 32'd1;
            state_nxt        = S_DIV_PSC;
          end else if (count_q > CNT_BITS'(COUNT_MAX)) begin
            count_nxt        = count_q;
            div_req.start    = 1'b1;
            div_req.narrow   = 1'b1;
            div_req.dividend = tpdc_pkg::DIV_FULL_W'(count_q);
            div_req.divisor  = 32'(COUNT_MAX);
            state_nxt        = S_DIV_CM;
          end else begin
            rld_nxt   = count_q[15:0] - 16'd1;
            state_nxt = S_CMP;
          end
        end
      end
      S_DIV_CM: begin
        if (div_rsp.done) begin
          psc_nxt          = quot16;
          sat_nxt          = sat_r | quot_big;
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b1;
          div_req.dividend = tpdc_pkg::DIV_FULL_W'(count_r);
          div_req.divisor  = 32'({1'b0, quot16}) + 32'd1;
          state_nxt        = S_DIV_RLD;
        end
      end
      S_DIV_RLD: begin
        if (div_rsp.done) begin
          rld_nxt   = quot16;
          sat_nxt   = sat_r | quot_big;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (act_r == tpdc_pkg::ACT_PWM && period_r != '0) begin
          mul_req.start = 1'b1;
          mul_req.a     = {16'd0, rld_r};
          mul_req.b     = duty_r;
          state_nxt     = S_MUL2;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MUL2: begin
        if (mul_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b1;
          div_req.dividend = mul_rsp.prod;
          div_req.divisor  = period_r;
          state_nxt        = S_DIV_CMP;
        end
      end
      S_DIV_CMP, S_DIV_PSC: begin
        if (div_rsp.done) begin
          cmp_nxt   = quot16;
          sat_nxt   = sat_r | quot_big;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          held_nxt      = psc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clk_hz_r    <= 32'd72000000;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        clk_hz_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    period_r <= period_nxt;
    duty_r   <= duty_nxt;
    count_r  <= count_nxt;
    psc_r    <= psc_nxt;
    rld_r    <= rld_nxt;
    cmp_r    <= cmp_nxt;
    sat_r    <= sat_nxt;
    if (out_load) begin
      out_psc_r    <= psc_r;
      out_rld_r    <= rld_r;
      out_cmp_r    <= cmp_r;
      out_status_r <= status_now;
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.prescaler = out_psc_r;
  assign out_ch.reload    = out_rld_r;
  assign out_ch.compare   = out_cmp_r;
  assign out_ch.status    = out_status_r;

endmodule

// ===== rtl/tpdc_mul.sv =====
module tpdc_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  tpdc_pkg::mul_req_t req,
  output tpdc_pkg::mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(tpdc_pkg::MUL_W);

  logic [tpdc_pkg::PROD_W-1:0] acc_r;
  logic [tpdc_pkg::MUL_W-1:0]  a_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [tpdc_pkg::MUL_W:0]    sum;

  // add the multiplicand into the upper half when the low multiplier bit is set
  assign sum = {1'b0, acc_r[tpdc_pkg::PROD_W-1:tpdc_pkg::MUL_W]}
             + (acc_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      acc_r <= {{tpdc_pkg::MUL_W{1'b0}}, req.b};
      cnt_r <= CNT_W'(tpdc_pkg::MUL_W - 1);
    end else if (busy_r) begin
      acc_r <= {sum, acc_r[tpdc_pkg::MUL_W-1:1]};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== rtl/tpdc_div.sv =====
module tpdc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tpdc_pkg::div_req_t req,
  output tpdc_pkg::div_rsp_t rsp
);

  localparam int CNT_W  = $clog2(tpdc_pkg::DIV_FULL_W);
  localparam int PAD_W  = tpdc_pkg::DIV_FULL_W - tpdc_pkg::DIV_NARROW_W;
  localparam int DVS_W  = tpdc_pkg::DVS_W;
  localparam int QUO_W  = tpdc_pkg::DIV_FULL_W;

  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [QUO_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial   = {rem_r, quo_r[QUO_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // shift dividend bits out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      if (req.narrow) begin
        quo_r <= {req.dividend[tpdc_pkg::DIV_NARROW_W-1:0], {PAD_W{1'b0}}};
        cnt_r <= CNT_W'(tpdc_pkg::DIV_NARROW_W - 1);
      end else begin
        quo_r <= req.dividend;
        cnt_r <= CNT_W'(tpdc_pkg::DIV_FULL_W - 1);
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QUO_W-2:0], fits};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

// ===== rtl/tpdc_checker.sv =====
module tpdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_prescaler,
  input logic [15:0] out_reload,
  input logic [15:0] out_compare,
  input logic [1:0]  out_status
);

  // hold the result word while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prescaler) &&
    $stable(out_reload) && $stable(out_compare) && $stable(out_status))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action != tpdc_pkg::ACT_NONE |=> !in_ready)
    else $error("input taken while a word is in work");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == tpdc_pkg::ST_OK || out_status == tpdc_pkg::ST_SAT ||
    out_status == tpdc_pkg::ST_ZERO)
    else $error("undefined status code");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tpdc_pkg::ST_ZERO |-> out_reload == '0 && out_compare == '0)
    else $error("zero period with nonzero reload or compare");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind timer_period_duty_calculator tpdc_checker u_tpdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_action     (in_ch.action),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_prescaler (out_ch.prescaler),
  .out_reload    (out_ch.reload),
  .out_compare   (out_ch.compare),
  .out_status    (out_ch.status)
);
